[hdl/bounded_deque_store_core_macros.svh]
// Assertion macros shared by the deque store RTL.
`ifndef BOUNDED_DEQUE_STORE_CORE_MACROS_SVH
`define BOUNDED_DEQUE_STORE_CORE_MACROS_SVH

// Clocked assertion, off while reset is high.
`define BDS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked in every cycle.
`define BDS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/bds_pkg.sv]
// Shared types and constants of the deque store.
package bds_pkg;

  localparam int DEPTH_DEF   = 64;
  localparam int DATA_W      = 32;
  localparam int REQ_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int COUNT_W     = 7;
  localparam int OUT_DATA_W  = 40;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DUMP       = 3'd4;
  localparam logic [REQ_W-1:0] REQ_COUNT      = 3'd5;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DUMP,
    OP_COUNT
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_t;

  typedef struct packed {
    logic [COUNT_W-1:0] occ;
    logic [COUNT_W-1:0] front;
    logic               dumping;
  } bstat_t;

endpackage

[hdl/bds_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/bds_fifo.sv]
// Short command queue between the request decoder and the executor.
module bds_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bds_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output bds_pkg::cmd_t pop_cmd,
  output logic          not_empty
);

  localparam int QD  = bds_pkg::QUEUE_DEPTH;
  localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCW = $clog2(QD + 1);
  localparam logic [QAW-1:0] QLAST = QAW'(QD - 1);

  bds_pkg::cmd_t  slots [QD];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;

  assign full      = (count == QCW'(QD));
  assign not_empty = (count != '0);
  assign pop_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QLAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QLAST) ? '0 : rd_ptr + 1'b1;
      end
      unique if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end else begin
        count <= count;
      end
    end
  end

endmodule

[hdl/bds_front.sv]
// Request intake: takes input transfers and decodes them into queue commands.
module bds_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [bds_pkg::DATA_W-1:0]   s_tdata,
  input  logic [bds_pkg::REQ_W-1:0]    s_tuser,
  input  logic                         q_full,
  output logic                         q_push,
  output bds_pkg::cmd_t                q_cmd
);

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_cmd.value = s_tdata;
    unique case (s_tuser)
      bds_pkg::REQ_PUSH_FRONT: q_cmd.op = bds_pkg::OP_PUSH_FRONT;
      bds_pkg::REQ_PUSH_BACK:  q_cmd.op = bds_pkg::OP_PUSH_BACK;
      bds_pkg::REQ_POP_FRONT:  q_cmd.op = bds_pkg::OP_POP_FRONT;
      bds_pkg::REQ_POP_BACK:   q_cmd.op = bds_pkg::OP_POP_BACK;
      bds_pkg::REQ_DUMP:       q_cmd.op = bds_pkg::OP_DUMP;
      default:                 q_cmd.op = bds_pkg::OP_COUNT;
    endcase
  end

endmodule

[hdl/bds_back.sv]
// Command executor: ring buffer control, entry RAM and output register.
module bds_back #(
  parameter int DEPTH = bds_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  bds_pkg::cmd_t                  cmd,
  output logic                           cmd_pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bds_pkg::DATA_W-1:0]     m_value,
  output logic [bds_pkg::COUNT_W-1:0]    m_count,
  output logic [bds_pkg::STATUS_W-1:0]   m_status,
  output logic                           m_last,
  output bds_pkg::bstat_t                stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(DEPTH);

  bds_pkg::state_t state, state_next;

  logic [AW-1:0] front, front_next;
  logic [CW-1:0] occ, occ_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [CW-1:0] idx, idx_next;

  logic          full, empty, out_free, last_hit;
  logic [AW-1:0] front_dec, front_inc, rd_inc, back_slot;
  logic [AW:0]   back_sum;

  logic                          we, re, load;
  logic [AW-1:0]                 waddr, raddr;
  logic [bds_pkg::DATA_W-1:0]    rdata;
  logic [bds_pkg::STATUS_W-1:0]  o_status;
  logic [bds_pkg::DATA_W-1:0]    o_value;
  logic                          o_last;

  assign full      = (occ == CW'(DEPTH));
  assign empty     = (occ == '0);
  assign out_free  = !m_tvalid || m_tready;
  assign last_hit  = (idx == occ - 1'b1);
  assign front_dec = (front == '0) ? LAST_IDX : front - 1'b1;
  assign front_inc = (front == LAST_IDX) ? '0 : front + 1'b1;
  assign rd_inc    = (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
  assign back_sum  = {1'b0, front} + {1'b0, occ[AW-1:0]};
  assign back_slot = (back_sum >= DEPTH_X) ? AW'(back_sum - DEPTH_X) : back_sum[AW-1:0];

  bds_ram #(
    .WIDTH (bds_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (cmd.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      bds_pkg::S_IDLE: begin
        if (cmd_valid && out_free && cmd.op == bds_pkg::OP_DUMP && !empty) begin
          state_next = bds_pkg::S_DUMP;
        end
      end
      bds_pkg::S_DUMP: begin
        if (out_free && last_hit) begin
          state_next = bds_pkg::S_IDLE;
        end
      end
      default: state_next = bds_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop     = 1'b0;
    load        = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = front_dec;
    raddr       = front;
    o_status    = bds_pkg::STAT_OK;
    o_value     = '0;
    o_last      = 1'b1;
    occ_next    = occ;
    front_next  = front;
    rd_ptr_next = rd_ptr;
    idx_next    = idx;
    unique case (state)
      bds_pkg::S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          load    = 1'b1;
          unique case (cmd.op)
            bds_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                o_status = bds_pkg::STAT_FULL;
              end else begin
                we         = 1'b1;
                waddr      = front_dec;
                front_next = front_dec;
                occ_next   = occ + 1'b1;
              end
            end
            bds_pkg::OP_PUSH_BACK: begin
              if (full) begin
                o_status = bds_pkg::STAT_FULL;
              end else begin
                we       = 1'b1;
                waddr    = back_slot;
                occ_next = occ + 1'b1;
              end
            end
            bds_pkg::OP_POP_FRONT: begin
              if (empty) begin
                o_status = bds_pkg::STAT_EMPTY;
              end else begin
                front_next = front_inc;
                occ_next   = occ - 1'b1;
              end
            end
            bds_pkg::OP_POP_BACK: begin
              if (empty) begin
                o_status = bds_pkg::STAT_EMPTY;
              end else begin
                occ_next = occ - 1'b1;
              end
            end
            bds_pkg::OP_DUMP: begin
              if (empty) begin
                o_status = bds_pkg::STAT_EMPTY;
              end else begin
                load        = 1'b0;
                re          = 1'b1;
                raddr       = front;
                rd_ptr_next = front_inc;
                idx_next    = '0;
              end
            end
            default: ;
          endcase
        end
      end
      bds_pkg::S_DUMP: begin
        if (out_free) begin
          load    = 1'b1;
          o_value = rdata;
          o_last  = last_hit;
          if (!last_hit) begin
            re          = 1'b1;
            raddr       = rd_ptr;
            rd_ptr_next = rd_inc;
            idx_next    = idx + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bds_pkg::S_IDLE;
      front    <= '0;
      occ      <= '0;
      rd_ptr   <= '0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      front    <= front_next;
      occ      <= occ_next;
      rd_ptr   <= rd_ptr_next;
      idx      <= idx_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_status <= o_status;
      m_value  <= o_value;
      m_count  <= bds_pkg::COUNT_W'(occ_next);
      m_last   <= o_last;
    end
  end

  assign stat.occ     = bds_pkg::COUNT_W'(occ);
  assign stat.front   = bds_pkg::COUNT_W'(front);
  assign stat.dumping = (state == bds_pkg::S_DUMP);

endmodule

[hdl/bounded_deque_store_core.sv]
// Top level of the bounded deque store: intake, command queue and executor.
//
// A double-ended queue of up to DEPTH signed 32-bit entries kept in a ring
// buffer RAM. Requests come in on the s_ stream (req_type in s_tuser, value in
// s_tdata) and pass through a two-entry command queue, so intake keeps going
// while the executor or the output side stalls, until the queue is full. Push,
// pop and count requests each give one result; a dump first starts the RAM
// read and then gives one entry per cycle while the output is free, set by
// the single registered RAM read port. The result of a push, pop or count
// request passes the command queue and then the output register before it is
// valid on the m_ stream; the first entry of a dump also passes the registered
// RAM read. Every request ends with a result that has m_tlast set. No clearing
// pass follows reset; the store is ready at once.
`include "bounded_deque_store_core_macros.svh"

module bounded_deque_store_core #(
  parameter int DEPTH = bds_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [bds_pkg::DATA_W-1:0]        s_tdata,   // value_in
  input  logic [bds_pkg::REQ_W-1:0]         s_tuser,   // req_type
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bds_pkg::OUT_DATA_W-1:0]    m_tdata,   // value_out, entry_count, zero pad
  output logic                              m_tlast,   // last
  output logic [bds_pkg::STATUS_W-1:0]      m_tuser    // status
);

  logic                          q_full, q_push, q_pop, q_not_empty;
  bds_pkg::cmd_t                 q_in, q_out;
  logic [bds_pkg::DATA_W-1:0]    m_value;
  logic [bds_pkg::COUNT_W-1:0]   m_count;
  bds_pkg::bstat_t               stat;

  bds_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  bds_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_cmd   (q_out),
    .not_empty (q_not_empty)
  );

  bds_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd       (q_out),
    .cmd_pop   (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_value   (m_value),
    .m_count   (m_count),
    .m_status  (m_tuser),
    .m_last    (m_tlast),
    .stat      (stat)
  );

  assign m_tdata = {1'b0, m_count, m_value};

  `BDS_ASSERT(a_occ_bound, clk, rst, stat.occ <= bds_pkg::COUNT_W'(DEPTH), "occupancy above depth")
  `BDS_ASSERT(a_front_bound, clk, rst, stat.front < bds_pkg::COUNT_W'(DEPTH), "front index out of range")
  `BDS_ASSERT(a_err_last, clk, rst, (m_tvalid && m_tuser != bds_pkg::STAT_OK) |-> m_tlast, "error result not last")
  `BDS_ASSERT(a_dump_nonempty, clk, rst, stat.dumping |-> (stat.occ != '0), "dump running on empty store")

endmodule
